### design/lru_key_value_cache_core_macros.svh
// assertion macros for the lru key-value cache core
// no dependencies; included by modules that carry concurrent checks
`ifndef LRU_KEY_VALUE_CACHE_CORE_MACROS_SVH
`define LRU_KEY_VALUE_CACHE_CORE_MACROS_SVH

// same-cycle implication, disabled while reset is asserted
`define LKVC_ASSERT_NOW(lbl, ck, rn, ante, cons, msg) \
    lbl: assert property (@(posedge ck) disable iff (!rn) (ante) |-> (cons)) else $error(msg);

// next-cycle implication, disabled while reset is asserted
`define LKVC_ASSERT_NEXT(lbl, ck, rn, ante, cons, msg) \
    lbl: assert property (@(posedge ck) disable iff (!rn) (ante) |=> (cons)) else $error(msg);

`endif

### design/lkvc_pkg.sv
// shared types and constants for the lru key-value cache core
// no dependencies; imported by lkvc_cell and lru_key_value_cache_core
`timescale 1ns / 1ps

package lkvc_pkg;

    localparam int KEY_W = 10;
    localparam int VAL_W = 32;
    localparam int CAP_W = 5;
    localparam logic [CAP_W-1:0] CAP_RESET = 5'd16;

    // operation codes
    localparam logic OP_GET = 1'b0;
    localparam logic OP_PUT = 1'b1;

    // sequencer states
    typedef enum logic {
        ST_IDLE,
        ST_UPDATE
    } state_t;

    // control broadcast from the sequencer to every cell
    typedef struct packed {
        logic cmp_en;
        logic upd_en;
        logic any_hit;
        logic is_put;
    } cell_ctrl_t;

endpackage

### design/lkvc_cell.sv
// one entry of the recency-ordered chain: key, value, valid and match flag
// depends on lkvc_pkg; instantiated in a row by lru_key_value_cache_core
`timescale 1ns / 1ps

module lkvc_cell
    import lkvc_pkg::*;
(
    input  logic                    clk,
    input  logic                    rst_n,
    input  cell_ctrl_t              ctrl,
    input  logic [KEY_W-1:0]        cmp_key,
    input  logic                    keep,
    input  logic                    prev_valid,
    input  logic [KEY_W-1:0]        prev_key,
    input  logic signed [VAL_W-1:0] prev_value,
    output logic                    valid,
    output logic [KEY_W-1:0]        key_q,
    output logic signed [VAL_W-1:0] value_q,
    input  logic                    found_in,
    input  logic signed [VAL_W-1:0] found_value_in,
    output logic                    found_out,
    output logic signed [VAL_W-1:0] found_value_out
);

    logic                    valid_reg;
    logic                    valid_next;
    logic                    match_reg;
    logic                    match_next;
    logic [KEY_W-1:0]        key_reg;
    logic signed [VAL_W-1:0] value_reg;
    logic                    shift_here;
    logic                    load;

    // hit at or beyond this cell moves this cell one place toward the back
    assign shift_here = match_reg | found_in;
    assign found_out  = shift_here;
    assign found_value_out = found_value_in | (match_reg ? value_reg : '0);

    // load from the front neighbor on a hit shift or on any put miss
    assign load = ctrl.upd_en & (ctrl.any_hit ? shift_here : ctrl.is_put);

    // a put miss drops entries that fall past the capacity
    assign valid_next = ctrl.any_hit ? prev_valid : (prev_valid & keep);

    // key compare at accept
    assign match_next = ctrl.cmp_en ? (valid_reg && (key_reg == cmp_key)) : match_reg;

    // control state
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg <= 1'b0;
            match_reg <= 1'b0;
        end
        else
        begin
            match_reg <= match_next;
            if (load)
            begin
                valid_reg <= valid_next;
            end
        end
    end

    // entry payload
    always_ff @(posedge clk)
    begin
        if (load)
        begin
            key_reg   <= prev_key;
            value_reg <= prev_value;
        end
    end

    assign valid   = valid_reg;
    assign key_q   = key_reg;
    assign value_q = value_reg;

endmodule

### design/lru_key_value_cache_core.sv
// top level of the lru key-value cache: sequencer, request registers, cell chain
// depends on lkvc_pkg, lkvc_cell and lru_key_value_cache_core_macros.svh
//
// channel   | handshake           | payload
// ----------+---------------------+--------------------------
// request   | start / busy        | opcode, key, value
// result    | done (one cycle)    | hit, read_value
// config    | cfg_valid/cfg_ready | cfg_data (capacity)
//
// at the accept edge every cell registers its key compare; in the update state
// the recency chain shifts and the result is registered.
// a get result shows on done in the cycle after the update; puts give no result.
// busy is high for the one update cycle; the result side cannot stall.
// reset clears all entries at once and sets capacity to 16; no clearing pass.
`timescale 1ns / 1ps

module lru_key_value_cache_core
    import lkvc_pkg::*;
#(
    parameter int MAX_ENTRIES = 16
)
(
    input  logic                    clk,
    input  logic                    rst_n,
    input  logic                    start,
    output logic                    busy,
    input  logic                    opcode,
    input  logic [KEY_W-1:0]        key,
    input  logic signed [VAL_W-1:0] value,
    output logic                    done,
    output logic                    hit,
    output logic signed [VAL_W-1:0] read_value,
    input  logic                    cfg_valid,
    output logic                    cfg_ready,
    input  logic [CAP_W-1:0]        cfg_data
);

`include "lru_key_value_cache_core_macros.svh"

    localparam int NW = $clog2(MAX_ENTRIES + 1);
    localparam int CW = (NW > CAP_W) ? NW : CAP_W;

    state_t                  state_reg;
    state_t                  state_next;
    logic [CAP_W-1:0]        capacity_reg;
    logic                    op_reg;
    logic [KEY_W-1:0]        key_reg;
    logic signed [VAL_W-1:0] value_reg;
    logic                    done_reg;
    logic                    done_next;
    logic                    hit_reg;
    logic                    hit_next;
    logic signed [VAL_W-1:0] read_value_reg;
    logic signed [VAL_W-1:0] read_value_next;
    logic                    accept;
    logic [CW-1:0]           cap_ext;
    logic [CW-1:0]           eff_cap;
    cell_ctrl_t              ctrl;

    // chain wiring: index i feeds cell i from the front, found runs back to front
    logic                    ch_valid [0:MAX_ENTRIES];
    logic [KEY_W-1:0]        ch_key   [0:MAX_ENTRIES];
    logic signed [VAL_W-1:0] ch_value [0:MAX_ENTRIES];
    logic                    fnd      [0:MAX_ENTRIES];
    logic signed [VAL_W-1:0] fnd_val  [0:MAX_ENTRIES];
    logic [MAX_ENTRIES-1:0]  keep;
    logic [MAX_ENTRIES-1:0]  valid_vec;

    assign accept    = start & (state_reg == ST_IDLE);
    assign busy      = (state_reg == ST_UPDATE);
    // capacity changes only when no item is accepted at the same edge
    assign cfg_ready = (state_reg == ST_IDLE) & !start;

    // capacity clamped to 1 .. MAX_ENTRIES
    assign cap_ext = CW'(capacity_reg);
    always_comb
    begin
        if (cap_ext == '0)
        begin
            eff_cap = CW'(1);
        end
        else if (cap_ext > CW'(MAX_ENTRIES))
        begin
            eff_cap = CW'(MAX_ENTRIES);
        end
        else
        begin
            eff_cap = cap_ext;
        end
    end

    // sequencer next state and outputs
    always_comb
    begin
        state_next      = state_reg;
        done_next       = 1'b0;
        hit_next        = 1'b0;
        read_value_next = '0;
        ctrl.cmp_en     = 1'b0;
        ctrl.upd_en     = 1'b0;
        ctrl.any_hit    = fnd[0];
        ctrl.is_put     = (op_reg == OP_PUT);
        case (state_reg)
            ST_IDLE:
            begin
                ctrl.cmp_en = start;
                if (start)
                begin
                    state_next = ST_UPDATE;
                end
            end
            ST_UPDATE:
            begin
                ctrl.upd_en = 1'b1;
                state_next  = ST_IDLE;
                if (op_reg == OP_GET)
                begin
                    done_next       = 1'b1;
                    hit_next        = fnd[0];
                    read_value_next = fnd_val[0];
                end
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    // control registers
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg    <= ST_IDLE;
            capacity_reg <= CAP_RESET;
            done_reg     <= 1'b0;
            hit_reg      <= 1'b0;
        end
        else
        begin
            state_reg <= state_next;
            done_reg  <= done_next;
            hit_reg   <= hit_next;
            if (cfg_valid && cfg_ready)
            begin
                capacity_reg <= cfg_data;
            end
        end
    end

    // request and result payload
    always_ff @(posedge clk)
    begin
        if (accept)
        begin
            op_reg    <= opcode;
            key_reg   <= key;
            value_reg <= value;
        end
        read_value_reg <= read_value_next;
    end

    assign done       = done_reg;
    assign hit        = hit_reg;
    assign read_value = read_value_reg;

    // front of the chain: the entry that becomes most recent
    assign ch_valid[0]          = 1'b1;
    assign ch_key[0]            = key_reg;
    assign ch_value[0]          = (op_reg == OP_PUT) ? value_reg : fnd_val[0];
    assign fnd[MAX_ENTRIES]     = 1'b0;
    assign fnd_val[MAX_ENTRIES] = '0;

    // row of cells, cell 0 most recent
    for (genvar i = 0; i < MAX_ENTRIES; i++)
    begin : g_cell
        assign keep[i]      = (CW'(i) < eff_cap);
        assign valid_vec[i] = ch_valid[i+1];

        lkvc_cell u_cell (
            .clk             (clk),
            .rst_n           (rst_n),
            .ctrl            (ctrl),
            .cmp_key         (key),
            .keep            (keep[i]),
            .prev_valid      (ch_valid[i]),
            .prev_key        (ch_key[i]),
            .prev_value      (ch_value[i]),
            .valid           (ch_valid[i+1]),
            .key_q           (ch_key[i+1]),
            .value_q         (ch_value[i+1]),
            .found_in        (fnd[i+1]),
            .found_value_in  (fnd_val[i+1]),
            .found_out       (fnd[i]),
            .found_value_out (fnd_val[i])
        );
    end

    // checks
    `LKVC_ASSERT_NEXT(a_accept_busy, clk, rst_n, accept, busy, "accepted item did not raise busy")
    `LKVC_ASSERT_NEXT(a_one_update, clk, rst_n, busy, !busy, "update lasted more than one cycle")
    `LKVC_ASSERT_NOW(a_done_after_update, clk, rst_n, done, $past(busy), "result without update")
    `LKVC_ASSERT_NOW(a_hit_needs_done, clk, rst_n, hit || (read_value != '0), done && hit, "hit or data outside a hit result")
    `LKVC_ASSERT_NOW(a_valid_packed, clk, rst_n, 1'b1, $onehot({1'b0, valid_vec} + 1'b1), "valid entries not packed at the front")

endmodule
